@@ hw/rtl/bwss_pkg.sv @@
// Package for the banked window span splitter.
// Types, register indexes and constants shared by the interfaces, controller,
// datapath and top level. No dependencies.
package bwss_pkg;

	localparam int unsigned X_W      = 12;
	localparam int unsigned LEN_W    = 14;
	localparam int unsigned POS_W    = 28;
	localparam int unsigned WIN_W    = 16;
	localparam int unsigned OFS_W    = 16;
	localparam int unsigned SEL_W    = 17;
	localparam int unsigned WSIZE_W  = 17;
	localparam int unsigned PITCH_W  = 15;
	localparam int unsigned UNITS_W  = 7;
	localparam int unsigned BANK_W   = 16;
	localparam int unsigned PROD_W   = X_W + PITCH_W;
	localparam int unsigned BPROD_W  = WIN_W + UNITS_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned DIV_STEPS  = POS_W;
	localparam int unsigned DCNT_W     = $clog2(DIV_STEPS);
	localparam int unsigned MAX_PIECES = 5;
	localparam int unsigned NPC_W      = $clog2(MAX_PIECES);

	localparam logic [SEL_W-1:0]   NONE_SELECTED = '1;
	localparam logic [WSIZE_W-1:0] WIN_MIN       = WSIZE_W'(4096);
	localparam logic [WSIZE_W-1:0] WIN_MAX       = WSIZE_W'(65536);
	localparam logic [PITCH_W-1:0] PITCH_RESET   = PITCH_W'(640);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH  = 3'd0,
		REG_SHIFT  = 3'd1,
		REG_WSIZE  = 3'd2,
		REG_UNITS  = 3'd3,
		REG_WSEL   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_PIECE
	} state_t;

	// effective configuration, already clamped
	typedef struct packed {
		logic [PITCH_W-1:0] pitch;
		logic [1:0]         shift;
		logic [WSIZE_W-1:0] wsize;
		logic [UNITS_W-1:0] units;
		logic               wsel;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
		logic more;
	} status_t;

	typedef struct packed {
		logic               switch_needed;
		logic               window_id;
		logic [BANK_W-1:0]  bank_value;
		logic               bank_overflow;
		logic [OFS_W-1:0]   window_offset;
		logic [LEN_W-1:0]   piece_length;
		logic [LEN_W-1:0]   source_offset;
		logic               row_end;
		logic               rect_end;
	} piece_t;

endpackage

@@ hw/rtl/bwss_if.sv @@
// Valid/ready channel interfaces for span requests and piece results.
// Depends on bwss_pkg for field widths.
interface bwss_in_if;
	import bwss_pkg::*;
	logic             valid;
	logic             ready;
	logic [X_W-1:0]   x_pixel;
	logic [X_W-1:0]   row_y;
	logic [X_W-1:0]   width_px;
	logic             last_row;
	modport source (output valid, x_pixel, row_y, width_px, last_row, input ready);
	modport sink   (input valid, x_pixel, row_y, width_px, last_row, output ready);
endinterface

interface bwss_out_if;
	import bwss_pkg::*;
	logic               valid;
	logic               ready;
	logic               switch_needed;
	logic               window_id;
	logic [BANK_W-1:0]  bank_value;
	logic               bank_overflow;
	logic [OFS_W-1:0]   window_offset;
	logic [LEN_W-1:0]   piece_length;
	logic [LEN_W-1:0]   source_offset;
	logic               row_end;
	logic               rect_end;
	modport source (output valid, switch_needed, window_id, bank_value, bank_overflow,
		window_offset, piece_length, source_offset, row_end, rect_end, input ready);
	modport sink   (input valid, switch_needed, window_id, bank_value, bank_overflow,
		window_offset, piece_length, source_offset, row_end, rect_end, output ready);
endinterface

@@ hw/rtl/bwss_ctrl.sv @@
// Controller state machine of the span splitter.
// Sequences multiply, add, serial divide and piece emission; uses bwss_pkg.
module bwss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bwss_pkg::status_t  status,
	output bwss_pkg::cmd_t     cmd
);
	import bwss_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_last) state_d = ST_PIECE;
			end
			ST_PIECE: begin
				if (status.out_free && !status.more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_ADD:   cmd.add = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_PIECE: cmd.emit = status.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ hw/rtl/bwss_dp.sv @@
// Datapath of the span splitter: address multiply, bit-serial divide by the
// window size, piece cutting, bank multiply and the output register. Uses bwss_pkg.
module bwss_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bwss_pkg::cfg_t              cfg,
	input  bwss_pkg::cmd_t              cmd,
	output bwss_pkg::status_t           status,
	input  logic [bwss_pkg::X_W-1:0]    x_pixel,
	input  logic [bwss_pkg::X_W-1:0]    row_y,
	input  logic [bwss_pkg::X_W-1:0]    width_px,
	input  logic                        last_row,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bwss_pkg::piece_t            out_piece
);
	import bwss_pkg::*;

	logic [X_W-1:0]     x_q;
	logic [X_W-1:0]     y_q;
	logic [X_W-1:0]     w_q;
	logic               last_q;
	logic [PROD_W-1:0]  prod_q;
	logic [POS_W-1:0]   dvd_q;
	logic [OFS_W-1:0]   rem_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [WIN_W-1:0]   win_q;
	logic [OFS_W-1:0]   ofs_q;
	logic [LEN_W-1:0]   linelen_q;
	logic [LEN_W-1:0]   covered_q;
	logic [NPC_W-1:0]   npc_q;
	logic [SEL_W-1:0]   sel_q;
	logic               out_valid_q;
	piece_t             piece_q;

	logic [LEN_W-1:0]   xs;
	logic [LEN_W-1:0]   ws_len;
	logic [OFS_W:0]     trial_src;
	logic [OFS_W+1:0]   trial;
	logic               trial_ok;
	logic [OFS_W-1:0]   rem_d;
	logic [POS_W-1:0]   dvd_d;
	logic [WSIZE_W-1:0] room;
	logic [LEN_W-1:0]   remaining;
	logic [LEN_W-1:0]   len;
	logic               rend;
	logic [BPROD_W-1:0] bank;
	piece_t             piece_d;

	assign xs     = LEN_W'({2'b00, x_q} << cfg.shift);
	assign ws_len = LEN_W'({2'b00, w_q} << cfg.shift);

	// restoring divide, one quotient bit per step
	assign trial_src = {rem_q, dvd_q[POS_W-1]};
	assign trial     = {1'b0, trial_src} - {1'b0, cfg.wsize};
	assign trial_ok  = !trial[OFS_W+1];
	assign rem_d     = trial_ok ? trial[OFS_W-1:0] : trial_src[OFS_W-1:0];
	assign dvd_d     = {dvd_q[POS_W-2:0], trial_ok};

	assign room      = cfg.wsize - WSIZE_W'(ofs_q);
	assign remaining = linelen_q - covered_q;
	assign len       = (room < WSIZE_W'(remaining)) ? room[LEN_W-1:0] : remaining;
	assign rend      = (len == remaining);
	assign bank      = BPROD_W'(win_q) * BPROD_W'(cfg.units);

	always_comb begin
		piece_d.switch_needed = (SEL_W'(win_q) != sel_q);
		piece_d.window_id     = cfg.wsel;
		piece_d.bank_value    = bank[BANK_W-1:0];
		piece_d.bank_overflow = |bank[BPROD_W-1:BANK_W];
		piece_d.window_offset = ofs_q;
		piece_d.piece_length  = len;
		piece_d.source_offset = covered_q;
		piece_d.row_end       = rend;
		piece_d.rect_end      = rend & last_q;
	end

	assign status.div_last = (cnt_q == '0);
	assign status.out_free = !out_valid_q || out_ready;
	assign status.more     = !rend && (npc_q != NPC_W'(MAX_PIECES - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_pixel;
			y_q    <= row_y;
			w_q    <= width_px;
			last_q <= last_row;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(y_q) * PROD_W'(cfg.pitch);
		end
		if (cmd.add) begin
			dvd_q     <= POS_W'(prod_q) + POS_W'(xs);
			rem_q     <= '0;
			cnt_q     <= DCNT_W'(DIV_STEPS - 1);
			linelen_q <= ws_len;
			covered_q <= '0;
			npc_q     <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == '0) begin
				win_q <= dvd_d[WIN_W-1:0];
				ofs_q <= rem_d;
			end
		end
		if (cmd.emit) begin
			piece_q   <= piece_d;
			covered_q <= covered_q + len;
			win_q     <= win_q + WIN_W'(1);
			ofs_q     <= '0;
			npc_q     <= npc_q + NPC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= NONE_SELECTED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				sel_q       <= SEL_W'(win_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_piece = piece_q;

endmodule

@@ hw/rtl/banked_window_span_splitter_unit.sv @@
// Banked window span splitter, top level. A request passes through multiply,
// add and a 28-step serial divide before the first piece, then one piece per
// cycle while taken; a span holds the block until its last piece is emitted.
// Reset clears the controller, output valid and the selected window to none
// selected, and the configuration registers to their defaults.
module banked_window_span_splitter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bwss_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bwss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	bwss_in_if.sink                           in_ch,
	bwss_out_if.source                        out_ch
);
	import bwss_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;
	piece_t  piece;
	logic    in_ready;
	logic    out_valid;
	logic [WSIZE_W-1:0] wsize_raw;

	assign wsize_raw = cfg_wdata[WSIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch <= PITCH_RESET;
			cfg_q.shift <= 2'd0;
			cfg_q.wsize <= WIN_MAX;
			cfg_q.units <= UNITS_W'(1);
			cfg_q.wsel  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PITCH: cfg_q.pitch <= cfg_wdata[PITCH_W-1:0];
				REG_SHIFT: cfg_q.shift <= (cfg_wdata[1:0] == 2'd3) ? 2'd2 : cfg_wdata[1:0];
				REG_WSIZE: begin
					priority if (wsize_raw < WIN_MIN) cfg_q.wsize <= WIN_MIN;
					else if (wsize_raw > WIN_MAX)     cfg_q.wsize <= WIN_MAX;
					else                               cfg_q.wsize <= wsize_raw;
				end
				REG_UNITS: cfg_q.units <= cfg_wdata[UNITS_W-1:0];
				REG_WSEL:  cfg_q.wsel  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	bwss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bwss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.status    (status),
		.x_pixel   (in_ch.x_pixel),
		.row_y     (in_ch.row_y),
		.width_px  (in_ch.width_px),
		.last_row  (in_ch.last_row),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_piece (piece)
	);

	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid;
	assign out_ch.switch_needed = piece.switch_needed;
	assign out_ch.window_id     = piece.window_id;
	assign out_ch.bank_value    = piece.bank_value;
	assign out_ch.bank_overflow = piece.bank_overflow;
	assign out_ch.window_offset = piece.window_offset;
	assign out_ch.piece_length  = piece.piece_length;
	assign out_ch.source_offset = piece.source_offset;
	assign out_ch.row_end       = piece.row_end;
	assign out_ch.rect_end      = piece.rect_end;

endmodule
